// ===== src/tsfu_pkg.sv =====
`timescale 1ns / 1ps

package tsfu_pkg;

	// fixed-point and range constants
	localparam int unsigned FRAC_BITS = 32;
	localparam logic [9:0] MAX_TERMS = 10'd1000;
	localparam logic [31:0] EPS_RESET = 32'd4295;
	localparam logic [49:0] PI_Q48 = 50'd884279719000798;
	localparam logic [47:0] PI_FIX = 48'(PI_Q48 >> (48 - FRAC_BITS));
	localparam logic [47:0] HALF_PI_FIX = PI_FIX >> 1;
	localparam logic [46:0] ONE_FIX = 47'(64'd1 << FRAC_BITS);
	localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
	localparam logic [63:0] TWO_POW_56 = 64'h0100_0000_0000_0000;

	// function select codes
	typedef enum logic [1:0] {
		FUNC_SIN  = 2'd0,
		FUNC_COS  = 2'd1,
		FUNC_EXP  = 2'd2,
		FUNC_ACOT = 2'd3
	} func_t;

	// multiplier operand choice and product shift
	typedef enum logic [1:0] {
		MUL_T,
		MUL_M,
		MUL_K
	} mul_sel_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_24,
		SH_32
	} sh_t;

	typedef enum logic {
		DIV_Y,
		DIV_T
	} div_sel_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_YDIV,
		S_FIRST,
		S_CHECK,
		S_MUL1,
		S_M2GO,
		S_MUL2,
		S_KGO,
		S_MUL3,
		S_DIVGO,
		S_DIV,
		S_FIX,
		S_DONE
	} state_t;

	// channel beats
	typedef struct packed {
		logic [1:0]         func_select;
		logic signed [31:0] x_value;
		logic [9:0]         term_limit;
	} tsfu_in_t;

	typedef struct packed {
		logic signed [47:0] result_value;
		logic [9:0]         term_count;
		logic               saturated;
	} tsfu_out_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     first;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     take_mul;
		logic     d_load;
		logic     div_go;
		div_sel_t div_sel;
		logic     ydone;
		logic     acc;
		logic     fix;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t fsel;
		logic  big;
		logic  cont;
		logic  mul_done;
		logic  div_done;
		logic  out_free;
	} status_t;

endpackage

// ===== src/taylor_series_function_unit.sv =====
`timescale 1ns / 1ps

// Taylor-series unit for sine, cosine, exponential and arc cotangent. One beat
// in gives one beat out. Each term is derived from the previous one with a
// 16x33 multiplier (two products for sine and cosine, one for exponential,
// three for arc cotangent) and a radix-2 divider; the divider dominates the
// cost of every term past the first. For arc cotangent with |x| > 1 a divide
// first forms 1/x. Summing stops at term_limit or once a term magnitude is
// at or below the epsilon register (units of 2^-32). A new beat is taken only
// once the previous one has reached the output register.

module taylor_series_function_unit
	import tsfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  tsfu_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output tsfu_out_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	cmd_t    cmd;
	status_t status;

	tsfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tsfu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

// ===== src/tsfu_mul.sv =====
`timescale 1ns / 1ps

module tsfu_mul
	import tsfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [32:0] b,
	input  sh_t         sh,
	output logic        done,
	output logic [63:0] res,
	output logic        sat
);

	logic [63:0] a_q;
	logic [32:0] b_q;
	sh_t         sh_q;
	logic [96:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] chunk;
	logic [48:0] pp;
	logic [96:0] pp_w;

	// one 16-bit slice of a per cycle
	assign chunk = a_q[{cnt_q, 4'b0000} +: 16];
	assign pp    = 49'(chunk) * 49'(b_q);
	assign pp_w  = 97'(pp) << {cnt_q, 4'b0000};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and partial product sum
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_w;
		end
	end

	// shifted product, all ones when it overflows 64 bits
	always_comb begin
		case (sh_q)
			SH_0: begin
				sat = |acc_q[96:64];
				res = acc_q[63:0];
			end
			SH_24: begin
				sat = |acc_q[96:88];
				res = acc_q[87:24];
			end
			SH_32: begin
				sat = acc_q[96];
				res = acc_q[95:32];
			end
			default: begin
				sat = 1'b0;
				res = acc_q[63:0];
			end
		endcase
		if (sat) begin
			res = '1;
		end
	end

	assign done = done_q;

endmodule

// ===== src/tsfu_div.sv =====
`timescale 1ns / 1ps

module tsfu_div
	import tsfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quot
);

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[63]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? diff[31:0] : trial[31:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== src/tsfu_dp.sv =====
`timescale 1ns / 1ps

module tsfu_dp
	import tsfu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  tsfu_in_t  in_data,
	input  logic      cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  cmd_t      cmd,
	output status_t   status,
	input  logic      out_stall,
	output logic      out_valid,
	output tsfu_out_t out_data
);

	logic [31:0]        eps_q;
	func_t              fsel_q;
	logic               xneg_q;
	logic [31:0]        xmag_q;
	logic [9:0]         limit_q;
	logic [32:0]        ymag_q;
	logic [46:0]        tmag_q;
	logic               tneg_q;
	logic signed [47:0] sum_q;
	logic [9:0]         iter_q;
	logic               sat_q;
	logic [63:0]        m_q;
	logic [21:0]        d_q;
	logic               out_valid_q;
	tsfu_out_t          out_q;

	logic [31:0]        in_xr;
	logic [31:0]        in_xmag;
	logic [9:0]         in_limit;
	logic               big;
	logic [10:0]        i2;
	logic [10:0]        odd;
	logic [21:0]        d_next;
	logic [63:0]        mul_a;
	logic [32:0]        mul_b;
	sh_t                mul_sh;
	logic               mul_done;
	logic [63:0]        mul_res;
	logic               mul_sat;
	logic [63:0]        div_n;
	logic [31:0]        div_d;
	logic               div_done;
	logic [63:0]        quot;
	logic               q_big;
	logic [46:0]        t_next;
	logic               tneg_next;
	logic signed [48:0] sum_w;
	logic signed [48:0] t_w;
	logic signed [48:0] acc_w;
	logic               acc_ovf;
	logic signed [48:0] fix_w;
	logic [46:0]        t_first;
	logic               tneg_first;

	// argument magnitude and clamped limit
	assign in_xr   = in_data.x_value;
	assign in_xmag = in_xr[31] ? (~in_xr + 32'd1) : in_xr;
	always_comb begin
		in_limit = in_data.term_limit;
		if (in_limit == 10'd0) begin
			in_limit = 10'd1;
		end else if (in_limit > MAX_TERMS) begin
			in_limit = MAX_TERMS;
		end
	end

	assign big = xmag_q > ONE_Q24;

	// divisor for the next term
	assign i2  = {iter_q, 1'b0};
	assign odd = i2 - 11'd1;
	always_comb begin
		case (fsel_q)
			FUNC_SIN:  d_next = 22'(i2) * 22'(i2 + 11'd1);
			FUNC_COS:  d_next = 22'(odd) * 22'(i2);
			FUNC_EXP:  d_next = 22'(iter_q);
			FUNC_ACOT: d_next = 22'(i2 + 11'd1);
			default:   d_next = 22'(iter_q);
		endcase
	end

	// multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_T: begin
				mul_a = 64'(tmag_q);
				mul_b = (fsel_q == FUNC_ACOT) ? ymag_q : 33'(xmag_q);
				mul_sh = (fsel_q == FUNC_ACOT) ? SH_32 : SH_24;
			end
			MUL_M: begin
				mul_a = m_q;
				mul_b = (fsel_q == FUNC_ACOT) ? ymag_q : 33'(xmag_q);
				mul_sh = (fsel_q == FUNC_ACOT) ? SH_32 : SH_24;
			end
			MUL_K: begin
				mul_a = m_q;
				mul_b = 33'(odd);
				mul_sh = SH_0;
			end
			default: begin
				mul_a = m_q;
				mul_b = '0;
				mul_sh = SH_0;
			end
		endcase
	end

	tsfu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat)
	);

	// divider operands
	assign div_n = (cmd.div_sel == DIV_Y) ? TWO_POW_56 : m_q;
	assign div_d = (cmd.div_sel == DIV_Y) ? xmag_q : 32'(d_q);

	tsfu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (quot)
	);

	// first term
	always_comb begin
		case (fsel_q)
			FUNC_SIN: begin
				t_first    = 47'(64'(xmag_q) << (FRAC_BITS - 24));
				tneg_first = xneg_q;
			end
			FUNC_ACOT: begin
				t_first    = 47'(ymag_q);
				tneg_first = xneg_q;
			end
			default: begin
				t_first    = ONE_FIX;
				tneg_first = 1'b0;
			end
		endcase
	end

	// term clamp and accumulation
	assign q_big     = |quot[63:47];
	assign t_next    = q_big ? '1 : quot[46:0];
	assign tneg_next = (fsel_q == FUNC_EXP) ? (tneg_q ^ xneg_q) : ~tneg_q;
	assign sum_w     = {sum_q[47], sum_q};
	assign t_w       = {2'b00, t_next};
	assign acc_w     = tneg_next ? (sum_w - t_w) : (sum_w + t_w);
	assign acc_ovf   = acc_w[48] != acc_w[47];

	// arc cotangent correction
	always_comb begin
		fix_w = sum_w;
		if (fsel_q == FUNC_ACOT) begin
			if (!big) begin
				fix_w = $signed({1'b0, HALF_PI_FIX}) - sum_w;
			end else if (xneg_q) begin
				fix_w = sum_w + $signed({1'b0, PI_FIX});
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fsel_q  <= func_t'(in_data.func_select);
			xneg_q  <= in_xr[31];
			xmag_q  <= in_xmag;
			limit_q <= in_limit;
			ymag_q  <= 33'({in_xmag, 8'h00});
			sat_q   <= 1'b0;
		end
		if (cmd.ydone) begin
			ymag_q <= quot[32:0];
		end
		if (cmd.first) begin
			tmag_q <= t_first;
			tneg_q <= tneg_first;
			sum_q  <= tneg_first ? -$signed({1'b0, t_first}) : $signed({1'b0, t_first});
			iter_q <= 10'd1;
		end
		if (cmd.d_load) begin
			d_q <= d_next;
		end
		if (cmd.take_mul) begin
			m_q <= mul_res;
			if (mul_sat) begin
				sat_q <= 1'b1;
			end
		end
		if (cmd.acc) begin
			tmag_q <= t_next;
			tneg_q <= tneg_next;
			iter_q <= iter_q + 10'd1;
			if (acc_ovf) begin
				sum_q <= acc_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
			end else begin
				sum_q <= acc_w[47:0];
			end
			if (acc_ovf || q_big) begin
				sat_q <= 1'b1;
			end
		end
		if (cmd.fix) begin
			if (fix_w[48] != fix_w[47]) begin
				sum_q <= fix_w[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
				sat_q <= 1'b1;
			end else begin
				sum_q <= fix_w[47:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.result_value <= sum_q;
			out_q.term_count   <= iter_q;
			out_q.saturated    <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status
	assign status.fsel     = fsel_q;
	assign status.big      = big;
	assign status.cont     = (iter_q < limit_q) && (tmag_q > 47'(eps_q));
	assign status.mul_done = mul_done;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

// ===== src/tsfu_ctrl.sv =====
`timescale 1ns / 1ps

module tsfu_ctrl
	import tsfu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_next = S_INIT;
			S_INIT: begin
				if (status.fsel == FUNC_ACOT && status.big) begin
					state_next = S_YDIV;
				end else begin
					state_next = S_FIRST;
				end
			end
			S_YDIV:  if (status.div_done) state_next = S_FIRST;
			S_FIRST: state_next = S_CHECK;
			S_CHECK: state_next = status.cont ? S_MUL1 : S_FIX;
			S_MUL1: begin
				if (status.mul_done) begin
					state_next = (status.fsel == FUNC_EXP) ? S_DIVGO : S_M2GO;
				end
			end
			S_M2GO:  state_next = S_MUL2;
			S_MUL2: begin
				if (status.mul_done) begin
					state_next = (status.fsel == FUNC_ACOT) ? S_KGO : S_DIVGO;
				end
			end
			S_KGO:   state_next = S_MUL3;
			S_MUL3:  if (status.mul_done) state_next = S_DIVGO;
			S_DIVGO: state_next = S_DIV;
			S_DIV:   if (status.div_done) state_next = S_CHECK;
			S_FIX:   state_next = S_DONE;
			S_DONE:  if (status.out_free) state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_T;
		cmd.div_sel = DIV_T;
		in_stall    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_INIT: begin
				if (status.fsel == FUNC_ACOT && status.big) begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = DIV_Y;
				end
			end
			S_YDIV: begin
				cmd.div_sel = DIV_Y;
				cmd.ydone   = status.div_done;
			end
			S_FIRST: cmd.first = 1'b1;
			S_CHECK: begin
				cmd.mul_go = status.cont;
				cmd.d_load = status.cont;
			end
			S_MUL1:  cmd.take_mul = status.mul_done;
			S_M2GO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_M;
			end
			S_MUL2:  cmd.take_mul = status.mul_done;
			S_KGO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_K;
			end
			S_MUL3:  cmd.take_mul = status.mul_done;
			S_DIVGO: cmd.div_go = 1'b1;
			S_DIV:   cmd.acc = status.div_done;
			S_FIX:   cmd.fix = 1'b1;
			S_DONE:  cmd.out_load = status.out_free;
			default: ;
		endcase
	end

	// multiplier finishes only while a multiply is awaited
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3))
		else $error("multiplier done outside a multiply wait");

	// divider finishes only while a divide is awaited
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == S_YDIV || state_q == S_DIV))
		else $error("divider done outside a divide wait");

	// an accepted beat starts the setup step
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_INIT)
		else $error("accepted beat did not start setup");

	// exhausted series goes to the final correction
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && !status.cont) |=> state_q == S_FIX)
		else $error("series end did not reach correction");

endmodule

// ===== test/tsfu_checker.sv =====
`timescale 1ns / 1ps

module tsfu_checker
	import tsfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  tsfu_in_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  tsfu_out_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	output int          errors,
	output int          pending
);

	localparam logic [63:0] MAG_MAX = 64'd140737488355327;
	localparam logic signed [63:0] SUM_HI = 64'sd140737488355327;
	localparam logic signed [63:0] SUM_LO = -64'sd140737488355328;

	logic [31:0] eps_reg;
	tsfu_out_t   series_q[$];

	// full 128-bit product, shifted, clamped to 64 bits on overflow
	function automatic logic [63:0] prod_shift(input logic [63:0] a, input logic [63:0] b,
			input int s, inout logic sat);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		if (p[127:64] != 0) begin
			sat = 1'b1;
			return '1;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] clamp_term(input logic [63:0] m, inout logic sat);
		if (m > MAG_MAX) begin
			sat = 1'b1;
			return MAG_MAX;
		end
		return m;
	endfunction

	function automatic logic signed [63:0] clamp_total(input logic signed [63:0] s,
			inout logic sat);
		if (s > SUM_HI) begin
			sat = 1'b1;
			return SUM_HI;
		end
		if (s < SUM_LO) begin
			sat = 1'b1;
			return SUM_LO;
		end
		return s;
	endfunction

	// series evaluation for one input beat
	function automatic tsfu_out_t eval_series(input tsfu_in_t b, input logic [31:0] eps);
		func_t              f;
		logic               xneg, sat, tneg, big;
		logic [63:0]        xmag, ymag, tmag, m, k, d;
		logic [127:0]       wide;
		logic signed [63:0] total;
		int                 lim, it;
		tsfu_out_t          r;
		f = func_t'(b.func_select);
		xneg = b.x_value[31];
		xmag = xneg ? 64'h1_0000_0000 - {32'd0, b.x_value} : {32'd0, b.x_value};
		lim = b.term_limit;
		sat = 1'b0;
		tneg = 1'b0;
		big = 1'b0;
		ymag = 0;
		it = 1;
		if (lim < 1) lim = 1;
		if (lim > MAX_TERMS) lim = MAX_TERMS;
		case (f)
			FUNC_SIN: begin
				tmag = xmag << 8;
				tneg = xneg;
			end
			FUNC_ACOT: begin
				big = xmag > 64'h100_0000;
				ymag = big ? TWO_POW_56 / xmag : xmag << 8;
				tmag = ymag;
				tneg = xneg;
			end
			default: tmag = 64'd1 << 32;
		endcase
		tmag = clamp_term(tmag, sat);
		total = tneg ? -$signed(tmag) : $signed(tmag);
		while (it < lim && tmag > {32'd0, eps}) begin
			case (f) inside
				FUNC_SIN, FUNC_COS: begin
					d = (f == FUNC_SIN) ? (2 * it) * (2 * it + 1) : (2 * it - 1) * (2 * it);
					m = prod_shift(tmag, xmag, 24, sat);
					m = prod_shift(m, xmag, 24, sat);
					m = m / d;
					tneg = !tneg;
				end
				FUNC_EXP: begin
					m = prod_shift(tmag, xmag, 24, sat) / it;
					tneg = tneg != xneg;
				end
				default: begin
					m = prod_shift(tmag, ymag, 32, sat);
					m = prod_shift(m, ymag, 32, sat);
					k = 2 * it - 1;
					wide = {64'd0, m} * {64'd0, k};
					if (wide[127:64] != 0) begin
						sat = 1'b1;
						m = '1;
					end else begin
						m = wide[63:0];
					end
					m = m / (2 * it + 1);
					tneg = !tneg;
				end
			endcase
			tmag = clamp_term(m, sat);
			total = clamp_total(tneg ? total - $signed(tmag) : total + $signed(tmag), sat);
			it++;
		end
		// arc cotangent range correction
		if (f == FUNC_ACOT) begin
			if (!big) total = $signed({16'd0, HALF_PI_FIX}) - total;
			else if (xneg) total = total + $signed({16'd0, PI_FIX});
			total = clamp_total(total, sat);
		end
		r.result_value = total[47:0];
		r.term_count = 10'(it);
		r.saturated = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	assign pending = series_q.size();

	// track epsilon register, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		tsfu_out_t want;
		if (!arst_n) begin
			eps_reg <= EPS_RESET;
			errors = 0;
			series_q.delete();
		end else begin
			if (cfg_wr_en) eps_reg <= cfg_wr_data;
			if (in_valid && !in_stall) series_q.push_back(eval_series(in_data, eps_reg));
			if (out_valid && !out_stall) begin
				if (series_q.size() == 0) begin
					report_mismatch("unexpected beat", 64'(out_data), 64'd0);
				end else begin
					want = series_q.pop_front();
					if (out_data.result_value !== want.result_value)
						report_mismatch("result_value", 64'(out_data.result_value),
							64'(want.result_value));
					if (out_data.term_count !== want.term_count)
						report_mismatch("term_count", 64'(out_data.term_count),
							64'(want.term_count));
					if (out_data.saturated !== want.saturated)
						report_mismatch("saturated", 64'(out_data.saturated),
							64'(want.saturated));
				end
			end
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tsfu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	tsfu_in_t    in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	tsfu_out_t   out_data;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	longint      cycle_count = 0;

	taylor_series_function_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	tsfu_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cycles <= 20000;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// run limit: end the test as failing once the cycle budget is used up
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd200_000_000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// valid stays up after an accepted beat until the next beat or an idle cycle
	task automatic send_beat(input func_t f, input logic [31:0] x, input logic [9:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func_select: f, x_value: x, term_limit: lim};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain_all;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_eps(input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly modest arguments and term counts, so runs converge quickly
	task automatic send_random;
		func_t       f;
		logic [31:0] x;
		logic [9:0]  lim;
		f = func_t'($urandom_range(3));
		case ($urandom_range(9))
			0: x = $urandom;
			1, 2: x = $urandom_range(32'h0800_0000) - 32'h0400_0000;
			default: x = $urandom_range(32'h0200_0000) - 32'h0100_0000;
		endcase
		case ($urandom_range(19))
			0: lim = 10'($urandom);
			1: lim = 10'($urandom_range(1023, 990));
			default: lim = 10'($urandom_range(40));
		endcase
		if (lim > 60 && x[31:27] != 5'h00 && x[31:27] != 5'h1f && f != FUNC_ACOT)
			lim = 10'($urandom_range(60));
		send_beat(f, x, lim);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each function, limit edge cases, acot branches
		send_beat(FUNC_SIN, 32'h0100_0000, 10'd20);
		send_beat(FUNC_COS, 32'hff00_0000, 10'd20);
		send_beat(FUNC_EXP, 32'h0100_0000, 10'd30);
		send_beat(FUNC_EXP, 32'hfe00_0000, 10'd30);
		send_beat(FUNC_ACOT, 32'h0080_0000, 10'd40);
		send_beat(FUNC_ACOT, 32'h0300_0000, 10'd40);
		send_beat(FUNC_ACOT, 32'hfd00_0000, 10'd40);
		send_beat(FUNC_ACOT, 32'h0100_0000, 10'd5);
		send_beat(FUNC_ACOT, 32'hff00_0000, 10'd5);
		send_beat(FUNC_SIN, 32'h0000_0000, 10'd0);
		send_beat(FUNC_COS, 32'h1234_5678, 10'd1);
		send_beat(FUNC_EXP, 32'h7fff_ffff, 10'd6);
		send_beat(FUNC_EXP, 32'h8000_0000, 10'd6);
		send_beat(FUNC_SIN, 32'h7fff_ffff, 10'd4);
		send_beat(FUNC_COS, 32'h8000_0000, 10'd4);
		send_beat(FUNC_ACOT, 32'h7fff_ffff, 10'd3);
		send_beat(FUNC_ACOT, 32'h8000_0000, 10'd3);
		send_beat(FUNC_ACOT, 32'h0000_0001, 10'd1023);
		send_beat(FUNC_SIN, 32'h0040_0000, 10'd1023);
		send_beat(FUNC_EXP, 32'h0600_0000, 10'd1000);
		// stop on the sender until every result is back
		drain_all();

		// long receiver hold-off while the sender keeps offering
		hold_req = ~hold_req;
		repeat (6) send_random();
		drain_all();

		write_eps(32'd0);
		send_idle_pct = 31;
		recv_idle_pct = 47;
		repeat (60) send_random();
		drain_all();

		write_eps(32'hffff_ffff);
		send_idle_pct = 47;
		recv_idle_pct = 31;
		repeat (60) send_random();
		drain_all();

		write_eps(32'd65536);
		repeat (60) send_random();
		drain_all();

		write_eps(32'd4295);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (84) send_random();
		drain_all();

		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
